// File: hw/rtl/npn_pkg.sv
// npn canonical form package: widths, controller codes, command and status types
`timescale 1ns / 1ps
package npn_pkg;
    localparam int TT_W       = 64;
    localparam int ORDER_W    = 8;
    localparam int FLIPS_W    = 4;
    localparam int CFG_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int DEF_MAX_INPUTS  = 4;
    localparam int DEF_MAX_OUTPUTS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'b1;

    typedef struct packed {
        logic load;     // latch table and counts, reset search
        logic eval;     // compare current candidate, step counters
    } t_npn_cmd;

    typedef struct packed {
        logic done;     // last candidate evaluated
    } t_npn_status;
endpackage

// File: hw/rtl/npn_if.sv
// valid/ready channel interfaces for the npn block
`timescale 1ns / 1ps
interface npn_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] truth_table;
    modport source (output valid, output truth_table, input ready);
    modport sink   (input valid, input truth_table, output ready);
endinterface

interface npn_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] canonical_table;
    logic [7:0]  input_order;
    logic [3:0]  input_flips;
    logic [3:0]  output_flips;
    modport source (output valid, output canonical_table, output input_order,
                    output input_flips, output output_flips, input ready);
    modport sink   (input valid, input canonical_table, input input_order,
                    input input_flips, input output_flips, output ready);
endinterface

interface npn_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [2:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/npn_ctrl.sv
// npn search controller state machine
`timescale 1ns / 1ps
module npn_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output npn_pkg::t_npn_cmd    o_cmd,
    input  npn_pkg::t_npn_status i_status
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.eval = 1'b1;
                if (i_status.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.eval && i_status.done) |=> o_out_valid) else $error("no result after done");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while holding result");
endmodule

// File: hw/rtl/npn_dp.sv
// npn search datapath: counters, candidate builder, best register
`timescale 1ns / 1ps
module npn_dp #(
    parameter int MAX_INPUTS  = npn_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = npn_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                        i_clk,
    input  npn_pkg::t_npn_cmd           i_cmd,
    output npn_pkg::t_npn_status        o_status,
    input  logic [npn_pkg::CFG_W-1:0]   i_input_count,
    input  logic [npn_pkg::CFG_W-1:0]   i_output_count,
    input  logic [npn_pkg::TT_W-1:0]    i_truth_table,
    output logic [npn_pkg::TT_W-1:0]    o_canonical_table,
    output logic [npn_pkg::ORDER_W-1:0] o_input_order,
    output logic [npn_pkg::FLIPS_W-1:0] o_input_flips,
    output logic [npn_pkg::FLIPS_W-1:0] o_output_flips
);
    localparam int TT_W = npn_pkg::TT_W;

    logic [2:0]  r_n, r_m, n_eff, m_eff;
    logic [TT_W-1:0] r_tt;
    logic [3:0]  r_neg, r_om;
    logic [1:0]  r_perm [4];
    logic [TT_W-1:0] r_bt;
    logic [1:0]  r_bp [4];
    logic [3:0]  r_bim, r_bom;

    // count clamping
    always_comb begin
        n_eff = i_input_count;
        m_eff = i_output_count;
        if (n_eff == 3'd0) n_eff = 3'd1;
        if (n_eff > 3'(MAX_INPUTS)) n_eff = 3'(MAX_INPUTS);
        if (m_eff == 3'd0) m_eff = 3'd1;
        if (m_eff > 3'(MAX_OUTPUTS)) m_eff = 3'(MAX_OUTPUTS);
    end

    logic [4:0]  rows;
    logic [6:0]  used;
    logic [TT_W-1:0] used_mask;
    assign rows = 5'd1 << r_n;
    assign used = 7'(rows) * 7'(r_m);
    assign used_mask = (used >= 7'd64) ? '1 : ((64'd1 << used[5:0]) - 64'd1);

    // candidate: permute, negate inputs, flip outputs
    logic [TT_W-1:0] pt, cand;
    logic [3:0] pim;
    logic [3:0] v, pr, omask;
    logic [3:0] o;
    always_comb begin
        pt = '0;
        pim = '0;
        omask = 4'((5'd1 << r_m) - 5'd1);
        for (int r = 0; r < 16; r++) begin
            v  = 4'(r) ^ r_neg;
            pr = '0;
            for (int k = 0; k < 4; k++)
                if (3'(k) < r_n) pr[k] = v[r_perm[k]];
            o = 4'(r_tt >> (r * 32'(r_m))) & omask;
            if (5'(r) < rows)
                pt = pt | (64'(o) << (32'(pr) * 32'(r_m)));
        end
        for (int k = 0; k < 4; k++)
            if (3'(k) < r_n && r_neg[k]) pim[r_perm[k]] = 1'b1;
        cand = pt;
        for (int r = 0; r < 16; r++)
            if (5'(r) < rows) cand = cand ^ (64'(r_om) << (r * 32'(r_m)));
    end

    // strict order: table, slots, input mask, output mask
    logic better, decided;
    always_comb begin
        better = 1'b0;
        decided = 1'b0;
        if (cand != r_bt) begin
            better = cand < r_bt;
            decided = 1'b1;
        end
        for (int k = 0; k < 4; k++)
            if (!decided && 3'(k) < r_n && r_perm[k] != r_bp[k]) begin
                better = r_perm[k] < r_bp[k];
                decided = 1'b1;
            end
        if (!decided && pim != r_bim) begin
            better = pim < r_bim;
            decided = 1'b1;
        end
        if (!decided) better = r_om < r_bom;
    end

    // lexicographic successor of the permutation
    logic [1:0] nx [4];
    logic       p_last;
    logic [2:0] pi, pj;
    logic       fi, fj;
    logic [1:0] t;
    always_comb begin
        for (int k = 0; k < 4; k++) nx[k] = r_perm[k];
        pi = '0;
        pj = '0;
        fi = 1'b0;
        fj = 1'b0;
        t  = '0;
        for (int k = 2; k >= 0; k--)
            if (!fi && 3'(k) + 3'd1 < r_n && r_perm[k] < r_perm[k+1]) begin
                pi = 3'(k);
                fi = 1'b1;
            end
        for (int k = 3; k >= 0; k--)
            if (!fj && 3'(k) < r_n && r_perm[k] > r_perm[pi[1:0]]) begin
                pj = 3'(k);
                fj = 1'b1;
            end
        p_last = !fi;
        if (fi) begin
            t = nx[pi[1:0]];
            nx[pi[1:0]] = nx[pj[1:0]];
            nx[pj[1:0]] = t;
            // reverse tail pi+1 .. n-1
            for (int a = 0; a < 4; a++)
                if (3'(a) > pi && 3'(a) < r_n)
                    nx[a] = r_perm[2'(r_n - 3'd1 + pi + 3'd1 - 3'(a))];
            for (int a = 0; a < 4; a++)
                if (3'(a) > pi && 3'(a) < r_n) begin
                    if (2'(r_n - 3'd1 + pi + 3'd1 - 3'(a)) == pj[1:0]) nx[a] = r_perm[pi[1:0]];
                end
        end
    end

    logic om_last, neg_last;
    assign om_last  = (5'(r_om) == (5'd1 << r_m) - 5'd1);
    assign neg_last = (5'(r_neg) == rows - 5'd1);
    assign o_status.done = i_cmd.eval && om_last && p_last && neg_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= n_eff;
            r_m   <= m_eff;
            r_tt  <= i_truth_table;
            r_neg <= '0;
            r_om  <= '0;
            r_bim <= '0;
            r_bom <= '0;
            for (int k = 0; k < 4; k++) begin
                r_perm[k] <= 2'(k);
                r_bp[k]   <= 2'(k);
            end
            r_bt <= '1; // replaced below by first candidate
        end else if (i_cmd.eval) begin
            if (better) begin
                r_bt  <= cand;
                r_bim <= pim;
                r_bom <= r_om;
                for (int k = 0; k < 4; k++) r_bp[k] <= r_perm[k];
            end
            if (!om_last) r_om <= r_om + 4'd1;
            else begin
                r_om <= '0;
                if (!p_last) begin
                    for (int k = 0; k < 4; k++) r_perm[k] <= nx[k];
                end else begin
                    for (int k = 0; k < 4; k++) r_perm[k] <= 2'(k);
                    r_neg <= r_neg + 4'd1;
                end
            end
        end
    end

    // first candidate equals the table masked to the used size under identity; best starts at all ones
    always_comb begin
        o_canonical_table = r_bt & used_mask;
        o_input_order = '0;
        for (int k = 0; k < 4; k++)
            if (3'(k) < r_n) o_input_order[2*k +: 2] = r_bp[k];
        o_input_flips  = r_bim;
        o_output_flips = r_bom;
    end

    // truth table bits above the used size never reach the candidate
    logic unused_ok;
    assign unused_ok = (used_mask != '0);
    a_mask: assert property (@(posedge i_clk) i_cmd.eval |-> unused_ok)
        else $error("empty mask");
endmodule

// File: hw/rtl/npn_canonical_form_top.sv
// npn canonical form top level: config registers, controller and datapath
`timescale 1ns / 1ps
// Exhaustive NPN canonicalizer. One truth table is taken per transaction and
// one canonical result returned. The search evaluates one candidate per cycle
// in a single compare unit, walking output masks innermost, then input
// permutations in lexicographic order, then input negation masks, so an item
// searches 2^n * n! * 2^m candidates (6144 at four inputs and four outputs).
// A new table is taken only after the result has been accepted. Counts must be
// written over the config channel only while idle; the block itself does not
// enforce this. Zero reads as one, values above the limits saturate.
module npn_canonical_form_top #(
    parameter int MAX_INPUTS  = npn_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = npn_pkg::DEF_MAX_OUTPUTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    npn_in_if.sink    in_ch,
    npn_out_if.source out_ch,
    npn_cfg_if.sink   cfg_ch
);
    logic [npn_pkg::CFG_W-1:0] r_input_count, r_output_count;
    npn_pkg::t_npn_cmd    cmd;
    npn_pkg::t_npn_status status;

    // config writes always accepted
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= 3'd4;
            r_output_count <= 3'd1;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                npn_pkg::REG_INPUT_COUNT:  r_input_count  <= cfg_ch.data;
                npn_pkg::REG_OUTPUT_COUNT: r_output_count <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    npn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    npn_dp #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_dp (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_input_count     (r_input_count),
        .i_output_count    (r_output_count),
        .i_truth_table     (in_ch.truth_table),
        .o_canonical_table (out_ch.canonical_table),
        .o_input_order     (out_ch.input_order),
        .o_input_flips     (out_ch.input_flips),
        .o_output_flips    (out_ch.output_flips)
    );
endmodule

// File: bench/npn_canonical_form_top_tb.sv
// testbench for the npn canonical form block: directed and random tables checked against a predictor
`timescale 1ns / 1ps
module npn_canonical_form_top_tb;
    logic i_clk;
    logic i_rst_n;

    npn_in_if  in_ch ();
    npn_out_if out_ch ();
    npn_cfg_if cfg_ch ();

    npn_canonical_form_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // one canonical result as the block returns it
    typedef struct packed {
        logic [npn_pkg::TT_W-1:0]    table_bits;
        logic [npn_pkg::ORDER_W-1:0] order;
        logic [npn_pkg::FLIPS_W-1:0] in_flips;
        logic [npn_pkg::FLIPS_W-1:0] out_flips;
    } t_canon;

    // shadow copy of the count registers
    logic [npn_pkg::CFG_W-1:0] inputs_reg;
    logic [npn_pkg::CFG_W-1:0] outputs_reg;

    t_canon canon_queue[$];
    int     mismatch_count;
    int     result_count;

    // idling controls, percent out of a hundred
    int send_gap_pct;
    int recv_stall_pct;

    // clock, period 10 ns
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // limit: worst-case search plus stalls, 119 items, taken many times over
    initial begin
        #400ms;
        $display("FAIL npn_canonical_form_top");
        $finish;
    end

    // lexicographic successor of a permutation
    function automatic bit next_perm(ref int p[4], input int n);
        int i;
        int j;
        int t;
        if (n < 2) return 1'b0;
        i = n - 2;
        while (i >= 0 && p[i] >= p[i+1]) i--;
        if (i < 0) return 1'b0;
        j = n - 1;
        while (p[j] <= p[i]) j--;
        t = p[i]; p[i] = p[j]; p[j] = t;
        for (i = i + 1, j = n - 1; i < j; i++, j--) begin
            t = p[i]; p[i] = p[j]; p[j] = t;
        end
        return 1'b1;
    endfunction

    // exhaustive search for the smallest npn-equivalent table
    function automatic t_canon canonicalize(logic [npn_pkg::TT_W-1:0] tt_in);
        int n;
        int m;
        int rows;
        logic [npn_pkg::TT_W-1:0] tt;
        logic [npn_pkg::TT_W-1:0] best_t;
        logic [npn_pkg::TT_W-1:0] pt;
        logic [npn_pkg::TT_W-1:0] flip;
        logic [npn_pkg::TT_W-1:0] cand;
        logic [npn_pkg::TT_W-1:0] o;
        int best_p[4];
        int perm[4];
        int best_im;
        int best_om;
        int pim;
        int v;
        int pr;
        bit better;
        bit decided;
        t_canon res;
        n = (inputs_reg == 0) ? 1 : (inputs_reg > 4 ? 4 : int'(inputs_reg));
        m = (outputs_reg == 0) ? 1 : (outputs_reg > 4 ? 4 : int'(outputs_reg));
        rows = 1 << n;
        tt = tt_in;
        if (rows * m < 64) tt = tt_in & ((64'd1 << (rows * m)) - 1);
        best_t = tt;
        best_im = 0;
        best_om = 0;
        for (int k = 0; k < 4; k++) best_p[k] = k;
        for (int neg = 0; neg < rows; neg++) begin
            for (int k = 0; k < 4; k++) perm[k] = k;
            do begin
                pt = '0;
                pim = 0;
                for (int r = 0; r < rows; r++) begin
                    v = r ^ neg;
                    pr = 0;
                    o = (tt >> (r * m)) & ((64'd1 << m) - 1);
                    for (int k = 0; k < n; k++) pr |= ((v >> perm[k]) & 1) << k;
                    pt |= o << (pr * m);
                end
                for (int k = 0; k < n; k++)
                    if (neg[k]) pim |= 1 << perm[k];
                for (int om = 0; om < (1 << m); om++) begin
                    flip = '0;
                    for (int r = 0; r < rows; r++) flip |= 64'(om) << (r * m);
                    cand = pt ^ flip;
                    // strict order: table, slots, input mask, output mask
                    decided = 1'b0;
                    better = 1'b0;
                    if (cand != best_t) begin
                        better = cand < best_t;
                        decided = 1'b1;
                    end
                    for (int k = 0; k < n && !decided; k++)
                        if (perm[k] != best_p[k]) begin
                            better = perm[k] < best_p[k];
                            decided = 1'b1;
                        end
                    if (!decided) better = (pim != best_im) ? pim < best_im : om < best_om;
                    if (better) begin
                        best_t = cand;
                        best_p = perm;
                        best_im = pim;
                        best_om = om;
                    end
                end
            end while (next_perm(perm, n));
        end
        res.table_bits = best_t;
        res.order = '0;
        for (int k = 0; k < n; k++) res.order[2*k +: 2] = best_p[k][1:0];
        res.in_flips = best_im[3:0];
        res.out_flips = best_om[3:0];
        return res;
    endfunction

    // receiver: random stall, compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_canon got;
                t_canon exp_r;
                got = {out_ch.canonical_table, out_ch.input_order,
                       out_ch.input_flips, out_ch.output_flips};
                if (canon_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: table %h order %h if %h of %h",
                                 got.table_bits, got.order, got.in_flips, got.out_flips);
                end else begin
                    exp_r = canon_queue.pop_front();
                    result_count++;
                    if (got !== exp_r) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h %h %h %h got %h %h %h %h",
                                     exp_r.table_bits, exp_r.order, exp_r.in_flips,
                                     exp_r.out_flips, got.table_bits, got.order,
                                     got.in_flips, got.out_flips);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // send one table and record its prediction once accepted; valid stays high
    // until the next idle cycle or drain lowers it
    task automatic send_table(logic [npn_pkg::TT_W-1:0] tt);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.truth_table <= tt;
        do @(posedge i_clk); while (!in_ch.ready);
        canon_queue.push_back(canonicalize(tt));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (canon_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_count(logic [npn_pkg::CFG_IDX_W-1:0] idx,
                               logic [npn_pkg::CFG_W-1:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == npn_pkg::REG_INPUT_COUNT) inputs_reg = val;
        else outputs_reg = val;
    endtask

    function automatic logic [npn_pkg::TT_W-1:0] rand_table();
        return {$urandom(), $urandom()};
    endfunction

    // reset defaults: extremes of the table, unused bits ignored
    task automatic test_defaults();
        send_table('0);
        send_table('1);
        send_table(64'hFFFF_FFFF_FFFF_0000);
        send_table(64'h0000_0000_0000_8000);
        send_table(64'h5555_5555_5555_6996);
    endtask

    // each clamped count from one to four, including zero and saturating settings
    task automatic test_counts();
        logic [npn_pkg::CFG_W-1:0] ins[7] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5, 3'd4};
        logic [npn_pkg::CFG_W-1:0] outs[7] = '{3'd4, 3'd0, 3'd3, 3'd2, 3'd7, 3'd1, 3'd6};
        for (int i = 0; i < 7; i++) begin
            write_count(npn_pkg::REG_INPUT_COUNT, ins[i]);
            write_count(npn_pkg::REG_OUTPUT_COUNT, outs[i]);
            send_table(rand_table());
            send_table(64'h1);
        end
    endtask

    // random tables over five random count settings at the given idling percentages
    task automatic test_random(int gap, int stall);
        send_gap_pct = gap;
        recv_stall_pct = stall;
        for (int s = 0; s < 5; s++) begin
            write_count(npn_pkg::REG_INPUT_COUNT, 3'($urandom_range(7)));
            write_count(npn_pkg::REG_OUTPUT_COUNT, 3'($urandom_range(7)));
            for (int i = 0; i < 5; i++) begin
                if ($urandom_range(3) == 0) send_table(64'($urandom_range(15)));
                else send_table(rand_table());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.truth_table = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        inputs_reg = 3'd4;
        outputs_reg = 3'd1;
        mismatch_count = 0;
        result_count = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_counts();
        test_random(0, 0);
        test_random(70, 0);
        drain();    // sender holds off until every result is back
        test_random(0, 70);
        test_random(14, 14);
        drain();
        if (mismatch_count == 0) begin
            $display("PASS npn_canonical_form_top");
        end else begin
            $display("FAIL npn_canonical_form_top");
        end
        $finish;
    end
endmodule
